>>> hw/rtl/sha256bc_pkg.sv
package sha256bc_pkg;

  localparam int unsigned WORD_W        = 32;
  localparam int unsigned HASH_WORDS    = 8;
  localparam int unsigned BLOCK_WORDS   = 16;
  localparam int unsigned ROUNDS        = 64;
  localparam int unsigned POS_W         = $clog2(BLOCK_WORDS);
  localparam int unsigned ROUND_W       = $clog2(ROUNDS);
  localparam int unsigned HIDX_W        = $clog2(HASH_WORDS);
  localparam int unsigned CFG_IDX_W     = 4;

  typedef logic [WORD_W-1:0] word_t;

  // configuration register map
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_HASH_A = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_HASH_H = 4'd7;

  localparam logic [POS_W-1:0]   POS_LAST   = POS_W'(BLOCK_WORDS - 1);
  localparam logic [ROUND_W-1:0] ROUND_LAST = ROUND_W'(ROUNDS - 1);

  typedef struct packed {
    word_t msg_word;
    logic  message_start;
  } in_t;

  typedef struct packed {
    word_t digest_0;
    word_t digest_1;
    word_t digest_2;
    word_t digest_3;
    word_t digest_4;
    word_t digest_5;
    word_t digest_6;
    word_t digest_7;
  } out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROUND,
    ST_FINAL
  } state_t;

  localparam word_t IV [HASH_WORDS] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam word_t ROUND_K [ROUNDS] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic word_t rotr(input word_t x, input int unsigned n);
    rotr = (x >> n) | (x << (WORD_W - n));
  endfunction

  function automatic word_t big_sig0(input word_t x);
    big_sig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic word_t big_sig1(input word_t x);
    big_sig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic word_t small_sig0(input word_t x);
    small_sig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic word_t small_sig1(input word_t x);
    small_sig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

endpackage

>>> hw/rtl/sha256_block_compress.sv
// Channel   Ports                              Transfer when
// input     start, busy, in_data               start && !busy at rising edge
// result    out_valid, out_data                out_valid high (one cycle)
// config    cfg_we, cfg_idx, cfg_wdata         cfg_we high at rising edge
//
// Words 0..14 of a block are taken one per cycle; busy stays low.
// The sixteenth word starts the rounds on the shared round unit, followed by
// the hash update; busy is high through both, so no new word is taken.
// The digest strobe is high in the first cycle that busy is low again.
// rst_n is synchronous; it restores the standard initial hash values.
// The receiver cannot stall: out_valid is held for exactly one cycle.
module sha256_block_compress
  import sha256bc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  in_t                  in_data,
  output logic                 out_valid,
  output out_t                 out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  word_t                cfg_wdata
);

  state_t             state_r, state_nxt;
  logic [POS_W-1:0]   pos_r, pos_nxt;
  logic [ROUND_W-1:0] round_r, round_nxt;
  logic               out_valid_r, out_valid_nxt;
  word_t              init_r [HASH_WORDS];
  word_t              hash_r [HASH_WORDS];
  word_t              hash_nxt [HASH_WORDS];
  word_t              wv_r [HASH_WORDS];
  word_t              wv_nxt [HASH_WORDS];
  word_t              win_r [BLOCK_WORDS];
  word_t              win_nxt [BLOCK_WORDS];

  logic  accept;
  word_t t1, t2, ch, maj, w_new;

  assign accept = start && (state_r == ST_IDLE);

  // shared round unit: one compression round and one schedule word per cycle
  always_comb begin
    ch    = (wv_r[4] & wv_r[5]) ^ (~wv_r[4] & wv_r[6]);
    maj   = (wv_r[0] & wv_r[1]) ^ (wv_r[0] & wv_r[2]) ^ (wv_r[1] & wv_r[2]);
    t1    = wv_r[7] + big_sig1(wv_r[4]) + ch + ROUND_K[round_r] + win_r[0];
    t2    = big_sig0(wv_r[0]) + maj;
    w_new = win_r[0] + small_sig0(win_r[1]) + win_r[9] + small_sig1(win_r[14]);
  end

  always_comb begin
    state_nxt     = state_r;
    pos_nxt       = pos_r;
    round_nxt     = round_r;
    out_valid_nxt = 1'b0;
    hash_nxt      = hash_r;
    wv_nxt        = wv_r;
    win_nxt       = win_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          // a start word reloads the hash and becomes word 0
          if (in_data.message_start) begin
            hash_nxt = init_r;
          end
          for (int i = 0; i < BLOCK_WORDS - 1; i++) begin
            win_nxt[i] = win_r[i+1];
          end
          win_nxt[BLOCK_WORDS-1] = in_data.msg_word;
          if (in_data.message_start) begin
            pos_nxt = POS_W'(1);
          end else begin
            pos_nxt = pos_r + POS_W'(1);
            if (pos_r == POS_LAST) begin
              wv_nxt    = hash_r;
              round_nxt = '0;
              state_nxt = ST_ROUND;
            end
          end
        end
      end
      ST_ROUND: begin
        for (int i = 0; i < BLOCK_WORDS - 1; i++) begin
          win_nxt[i] = win_r[i+1];
        end
        win_nxt[BLOCK_WORDS-1] = w_new;
        wv_nxt[7] = wv_r[6];
        wv_nxt[6] = wv_r[5];
        wv_nxt[5] = wv_r[4];
        wv_nxt[4] = wv_r[3] + t1;
        wv_nxt[3] = wv_r[2];
        wv_nxt[2] = wv_r[1];
        wv_nxt[1] = wv_r[0];
        wv_nxt[0] = t1 + t2;
        round_nxt = round_r + ROUND_W'(1);
        if (round_r == ROUND_LAST) begin
          state_nxt = ST_FINAL;
        end
      end
      ST_FINAL: begin
        for (int i = 0; i < HASH_WORDS; i++) begin
          hash_nxt[i] = hash_r[i] + wv_r[i];
        end
        out_valid_nxt = 1'b1;
        state_nxt     = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      round_r     <= '0;
      out_valid_r <= 1'b0;
      init_r      <= IV;
      hash_r      <= IV;
    end else begin
      pos_r       <= pos_nxt;
      round_r     <= round_nxt;
      out_valid_r <= out_valid_nxt;
      hash_r      <= hash_nxt;
      // indexes past the last register are dropped
      if (cfg_we && cfg_idx <= CFG_INIT_HASH_H) begin
        init_r[cfg_idx[HIDX_W-1:0]] <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    wv_r  <= wv_nxt;
    win_r <= win_nxt;
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = '{digest_0: hash_r[0], digest_1: hash_r[1],
                       digest_2: hash_r[2], digest_3: hash_r[3],
                       digest_4: hash_r[4], digest_5: hash_r[5],
                       digest_6: hash_r[6], digest_7: hash_r[7]};

`ifndef ASSERT_OFF
  a_strobe_after_final: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(state_r == ST_FINAL))
    else $error("digest strobe without hash update");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r)
    else $error("digest strobe longer than one cycle");

  a_round_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ROUND && round_r != ROUND_LAST) |=>
      (state_r == ST_ROUND && round_r == $past(round_r) + ROUND_W'(1)))
    else $error("round counter skipped or left early");

  a_busy_from_last_word: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> $past(accept && pos_r == POS_LAST && !in_data.message_start))
    else $error("compression started without a full block");

  a_idle_round_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FINAL) |-> (round_r == '0))
    else $error("round counter did not wrap at block end");
`endif

endmodule
